// ----- hw/rtl/bbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_pkg
// Types and codes shared by the bounds refit block.
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam logic [8:0] MAX_NODES     = 9'd256;
    localparam logic [8:0] MAX_INSTANCES = 9'd256;

    localparam logic [31:0] POS_INF = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF = 32'hFF80_0000;

    // map entry with no parent / no covering leaf
    localparam logic [8:0] NO_LINK = 9'h100;

    typedef enum logic [1:0] {
        CMD_WR_NODE = 2'd0,
        CMD_WR_INST = 2'd1,
        CMD_REFIT   = 2'd2,
        CMD_RD_NODE = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REBUILD = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_INST_COUNT = 1'b1;

    typedef struct packed {
        logic [31:0] min_x;
        logic [31:0] min_y;
        logic [31:0] min_z;
        logic [31:0] max_x;
        logic [31:0] max_y;
        logic [31:0] max_z;
    } box_t;

    typedef struct packed {
        logic       is_leaf;
        logic [7:0] first;
        logic [8:0] link;
        box_t       box;
    } node_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  index;
        logic        is_leaf;
        logic [7:0]  first;
        logic [8:0]  link;
        logic        mark_dirty;
        logic [31:0] box_min_x;
        logic [31:0] box_min_y;
        logic [31:0] box_min_z;
        logic [31:0] box_max_x;
        logic [31:0] box_max_y;
        logic [31:0] box_max_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] revision;
        logic [31:0] out_min_x;
        logic [31:0] out_min_y;
        logic [31:0] out_min_z;
        logic [31:0] out_max_x;
        logic [31:0] out_max_y;
        logic [31:0] out_max_z;
    } out_item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bvh_bounds_refit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvh_bounds_refit
// Array BVH node/instance box store with in-place refit sequencer.
// ----------------------------------------------------------------------------
// Writes complete in idle. Node read: node memory read, result register, then
// output register; next input taken once the result is loaded. Refit: dirty
// scan (up to ic), clear of all 256 map entries, checks of each node and each
// leaf's instances, mark walk up from each dirty instance's leaf, recompute of
// dirty nodes from the last down, then the result. Reset clears dirty bits and
// revision, sets nc to 1 and ic to 0; stores undefined until written.
module bvh_bounds_refit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [8:0]          cfg_data,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  bbr_pkg::in_item_t        in_data,
    output      logic                out_valid,
    input  wire logic                out_stall,
    output bbr_pkg::out_item_t       out_data
);
    import bbr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_W, S_ANY, S_CLR, S_VAL_RD, S_VAL_W, S_LEAF, S_PAR2,
        S_MARK, S_MARK_W, S_WALK, S_WALK_W, S_RC, S_RC_W, S_LF_RD, S_LF_W,
        S_IN_A_W, S_IN_B_W, S_OUT
    } state_t;

    state_t      state_reg;
    logic [8:0]  nc_cfg_reg, ic_cfg_reg;
    logic [8:0]  nc, ic;
    logic [8:0]  i_reg, k_reg;
    logic [7:0]  n_reg;
    logic [7:0]  cur_f_reg;
    logic [8:0]  cur_l_reg;
    node_t       cur_reg;
    box_t        acc_reg, boxa_reg;
    logic [31:0] rev_reg;
    out_item_t   res_reg, out_reg;
    logic        out_valid_reg;
    logic [255:0] inst_dirty_reg, node_dirty_reg;

    node_t node_mem [256];
    box_t  inst_mem [256];
    logic [8:0] par_mem [256];
    logic [8:0] leaf_mem [256];

    node_t      node_rdata_reg;
    box_t       inst_rdata_reg;
    logic [8:0] par_rdata_reg, leaf_rdata_reg;

    logic       node_we, inst_we, par_we, leaf_we;
    logic [7:0] node_waddr, node_raddr, inst_raddr, par_waddr, leaf_waddr;
    logic [8:0] par_wdata, leaf_wdata;
    node_t      node_wdata;
    box_t       in_box, merge_a, merge_b, merged;
    logic       in_take;
    logic       out_load;
    logic [7:0] i8, im1;
    logic [7:0] lf_addr;

    assign nc = (nc_cfg_reg > MAX_NODES) ? MAX_NODES : nc_cfg_reg;
    assign ic = (ic_cfg_reg > MAX_INSTANCES) ? MAX_INSTANCES : ic_cfg_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign in_take = in_valid && !in_stall;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign i8 = i_reg[7:0];
    assign im1 = 8'(i_reg - 9'd1);
    assign lf_addr = 8'({1'b0, cur_f_reg} + k_reg);

    assign in_box = '{in_data.box_min_x, in_data.box_min_y, in_data.box_min_z,
                      in_data.box_max_x, in_data.box_max_y, in_data.box_max_z};

    assign merge_a = (state_reg == S_LF_W) ? acc_reg : boxa_reg;
    assign merge_b = (state_reg == S_LF_W) ? inst_rdata_reg : node_rdata_reg.box;

    bbr_box_merge u_merge (
        .a (merge_a),
        .b (merge_b),
        .y (merged)
    );

    always_comb
    begin
        node_raddr = i8;
        unique case (state_reg)
            S_IDLE:   node_raddr = in_data.index;
            S_RC:     node_raddr = im1;
            S_RC_W:   node_raddr = node_rdata_reg.first;
            S_IN_A_W: node_raddr = cur_reg.link[7:0];
            default:  node_raddr = i8;
        endcase
        inst_raddr = lf_addr;

        node_we = 1'b0;
        node_waddr = n_reg;
        node_wdata = '{cur_reg.is_leaf, cur_reg.first, cur_reg.link, merged};
        if (state_reg == S_IDLE && in_take && in_data.cmd == CMD_WR_NODE)
        begin
            node_we = 1'b1;
            node_waddr = in_data.index;
            node_wdata = '{in_data.is_leaf, in_data.first, in_data.link, in_box};
        end
        else if ((state_reg == S_LF_W && k_reg + 9'd1 == cur_reg.link) ||
                 state_reg == S_IN_B_W)
        begin
            node_we = 1'b1;
        end

        inst_we = (state_reg == S_IDLE) && in_take && (in_data.cmd == CMD_WR_INST);

        // clear pass fills both maps with NO_LINK before they are rebuilt
        par_wdata = (state_reg == S_CLR) ? NO_LINK : {1'b0, i8};
        par_we = 1'b0;
        par_waddr = node_rdata_reg.first;
        if (state_reg == S_CLR)
        begin
            par_we = 1'b1;
            par_waddr = i8;
        end
        else if (state_reg == S_VAL_W && !node_rdata_reg.is_leaf)
            par_we = 1'b1;
        else if (state_reg == S_PAR2)
        begin
            par_we = 1'b1;
            par_waddr = cur_l_reg[7:0];
        end

        leaf_wdata = (state_reg == S_CLR) ? NO_LINK : {1'b0, i8};
        leaf_we = (state_reg == S_LEAF) || (state_reg == S_CLR);
        leaf_waddr = (state_reg == S_CLR) ? i8 : lf_addr;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (inst_we)
            inst_mem[in_data.index] <= in_box;
        inst_rdata_reg <= inst_mem[inst_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_waddr] <= par_wdata;
        par_rdata_reg <= par_mem[n_reg];
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_waddr] <= leaf_wdata;
        leaf_rdata_reg <= leaf_mem[i8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nc_cfg_reg     <= 9'd1;
            ic_cfg_reg     <= 9'd0;
            i_reg          <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            rev_reg        <= '0;
            out_valid_reg  <= 1'b0;
            inst_dirty_reg <= '0;
            node_dirty_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_NODE_COUNT)
                    nc_cfg_reg <= cfg_data;
                else
                    ic_cfg_reg <= cfg_data;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        unique case (cmd_t'(in_data.cmd))
                            CMD_WR_NODE: ;
                            CMD_WR_INST:
                                if (in_data.mark_dirty)
                                    inst_dirty_reg[in_data.index] <= 1'b1;
                            CMD_RD_NODE: state_reg <= S_RD_W;
                            CMD_REFIT:
                            begin
                                res_reg <= '{((ic != 9'd0) && (nc == 9'd0)) ?
                                             ST_REBUILD : ST_OK,
                                             rev_reg, 32'd0, 32'd0, 32'd0,
                                             32'd0, 32'd0, 32'd0};
                                i_reg <= '0;
                                state_reg <= (ic == 9'd0 || nc == 9'd0) ? S_OUT : S_ANY;
                            end
                        endcase
                    end
                end
                S_RD_W:
                begin
                    res_reg <= '{ST_READ, rev_reg,
                                 node_rdata_reg.box.min_x, node_rdata_reg.box.min_y,
                                 node_rdata_reg.box.min_z, node_rdata_reg.box.max_x,
                                 node_rdata_reg.box.max_y, node_rdata_reg.box.max_z};
                    state_reg <= S_OUT;
                end
                S_ANY:
                begin
                    if (inst_dirty_reg[i8])
                    begin
                        i_reg <= '0;
                        state_reg <= S_CLR;
                    end
                    else if (i_reg + 9'd1 == ic)
                    begin
                        res_reg.status <= ST_OK;
                        state_reg <= S_OUT;
                    end
                    else
                        i_reg <= i_reg + 9'd1;
                end
                S_CLR:
                begin
                    if (i8 == 8'hFF)
                    begin
                        i_reg <= '0;
                        state_reg <= S_VAL_RD;
                    end
                    else
                        i_reg <= i_reg + 9'd1;
                end
                S_VAL_RD:
                    state_reg <= S_VAL_W;
                S_VAL_W:
                begin
                    cur_f_reg <= node_rdata_reg.first;
                    cur_l_reg <= node_rdata_reg.link;
                    k_reg <= '0;
                    if (node_rdata_reg.is_leaf)
                    begin
                        if (node_rdata_reg.link == 9'd0 ||
                            10'(node_rdata_reg.first) + 10'(node_rdata_reg.link) > 10'(ic))
                        begin
                            res_reg.status <= ST_REBUILD;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_LEAF;
                    end
                    else if ({1'b0, node_rdata_reg.first} >= nc || node_rdata_reg.link >= nc)
                    begin
                        res_reg.status <= ST_REBUILD;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_PAR2;
                end
                S_LEAF, S_PAR2:
                begin
                    if (state_reg == S_LEAF)
                        k_reg <= k_reg + 9'd1;
                    if (state_reg == S_PAR2 || k_reg + 9'd1 == cur_l_reg)
                    begin
                        if (i_reg + 9'd1 == nc)
                        begin
                            i_reg <= '0;
                            node_dirty_reg <= '0;
                            state_reg <= S_MARK;
                        end
                        else
                        begin
                            i_reg <= i_reg + 9'd1;
                            state_reg <= S_VAL_RD;
                        end
                    end
                end
                S_MARK:
                begin
                    if (inst_dirty_reg[i8])
                        state_reg <= S_MARK_W;
                    else if (i_reg + 9'd1 == ic)
                    begin
                        i_reg <= nc;
                        state_reg <= S_RC;
                    end
                    else
                        i_reg <= i_reg + 9'd1;
                end
                S_MARK_W:
                begin
                    // dirty instance that no leaf covers
                    if (leaf_rdata_reg[8])
                    begin
                        res_reg.status <= ST_REBUILD;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        n_reg <= leaf_rdata_reg[7:0];
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (!node_dirty_reg[n_reg])
                    begin
                        node_dirty_reg[n_reg] <= 1'b1;
                        state_reg <= S_WALK_W;
                    end
                    else if (i_reg + 9'd1 == ic)
                    begin
                        i_reg <= nc;
                        state_reg <= S_RC;
                    end
                    else
                    begin
                        i_reg <= i_reg + 9'd1;
                        state_reg <= S_MARK;
                    end
                end
                S_WALK_W:
                begin
                    if (!par_rdata_reg[8])
                    begin
                        n_reg <= par_rdata_reg[7:0];
                        state_reg <= S_WALK;
                    end
                    else if (i_reg + 9'd1 == ic)
                    begin
                        i_reg <= nc;
                        state_reg <= S_RC;
                    end
                    else
                    begin
                        i_reg <= i_reg + 9'd1;
                        state_reg <= S_MARK;
                    end
                end
                S_RC:
                begin
                    if (i_reg == 9'd0)
                    begin
                        inst_dirty_reg <= '0;
                        rev_reg <= rev_reg + 32'd1;
                        res_reg.revision <= rev_reg + 32'd1;
                        state_reg <= S_OUT;
                    end
                    else if (node_dirty_reg[im1])
                    begin
                        n_reg <= im1;
                        state_reg <= S_RC_W;
                    end
                    else
                        i_reg <= i_reg - 9'd1;
                end
                S_RC_W:
                begin
                    cur_reg <= node_rdata_reg;
                    cur_f_reg <= node_rdata_reg.first;
                    k_reg <= '0;
                    acc_reg <= '{POS_INF, POS_INF, POS_INF, NEG_INF, NEG_INF, NEG_INF};
                    state_reg <= node_rdata_reg.is_leaf ? S_LF_RD : S_IN_A_W;
                end
                S_LF_RD:
                    state_reg <= S_LF_W;
                S_LF_W:
                begin
                    acc_reg <= merged;
                    k_reg <= k_reg + 9'd1;
                    if (k_reg + 9'd1 == cur_reg.link)
                    begin
                        i_reg <= i_reg - 9'd1;
                        state_reg <= S_RC;
                    end
                    else
                        state_reg <= S_LF_RD;
                end
                S_IN_A_W:
                begin
                    boxa_reg <= node_rdata_reg.box;
                    state_reg <= S_IN_B_W;
                end
                S_IN_B_W:
                begin
                    i_reg <= i_reg - 9'd1;
                    state_reg <= S_RC;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bbr_box_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_box_merge
// Per-axis float min/max of two boxes; a NaN keeps the first operand.
// ----------------------------------------------------------------------------
module bbr_box_merge (
    input  bbr_pkg::box_t a,
    input  bbr_pkg::box_t b,
    output bbr_pkg::box_t y
);
    import bbr_pkg::*;

    function automatic logic f32_lt(input logic [31:0] p, input logic [31:0] q);
        logic p_nan;
        logic q_nan;
        logic r;
        p_nan = (&p[30:23]) && (|p[22:0]);
        q_nan = (&q[30:23]) && (|q[22:0]);
        if (p_nan || q_nan || (p[30:0] == 31'd0 && q[30:0] == 31'd0))
            r = 1'b0;
        else if (p[31] && !q[31])
            r = 1'b1;
        else if (!p[31] && q[31])
            r = 1'b0;
        else if (!p[31])
            r = p[30:0] < q[30:0];
        else
            r = p[30:0] > q[30:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_min(input logic [31:0] p, input logic [31:0] q);
        return f32_lt(q, p) ? q : p;
    endfunction

    function automatic logic [31:0] pick_max(input logic [31:0] p, input logic [31:0] q);
        return f32_lt(p, q) ? q : p;
    endfunction

    always_comb
    begin
        y.min_x = pick_min(a.min_x, b.min_x);
        y.min_y = pick_min(a.min_y, b.min_y);
        y.min_z = pick_min(a.min_z, b.min_z);
        y.max_x = pick_max(a.max_x, b.max_x);
        y.max_y = pick_max(a.max_y, b.max_y);
        y.max_z = pick_max(a.max_z, b.max_z);
    end

endmodule
`default_nettype wire
